/* hw/rtl/ncs_pkg.sv */
// Shared constants and types of the NAL start code splitter.
package ncs_pkg;

  // Default width of the payload byte counter inside the block.
  localparam int unsigned DefaultLengthBits = 24;

  // Zero bytes held back while a start code may still be forming.
  localparam logic [1:0] MaxHeldZeros  = 2'd3;
  localparam logic [1:0] StartMinZeros = 2'd2;

  // A single item can release up to four zero bytes as payload.
  localparam int unsigned ZeroCntW = 3;

  // Field widths of the result items.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NumW      = 32;
  localparam int unsigned FieldLenW = 24;
  localparam logic [FieldLenW-1:0] FieldLenMax = {FieldLenW{1'b1}};

  // Depth of the command queue between front and back end.
  localparam int unsigned QueueDepth = 4;

  // Start code byte that follows the zeros.
  localparam logic [ByteW-1:0] StartByte = 8'h01;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

endpackage

/* hw/rtl/ncs_front.sv */
// Front end: tracks held zeros and open NAL units, and turns each byte into a command.
module ncs_front
  import ncs_pkg::*;
#(
  parameter int unsigned LengthBits = DefaultLengthBits,
  parameter int unsigned CmdW       = 3 + ZeroCntW + ByteW + NumW + 2 * LengthBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             end_of_stream_i,
  input  logic             valid_i,
  output logic             ready_o,
  output logic             push_o,
  output logic [CmdW-1:0]  cmd_o,
  input  logic             full_i
);

  typedef struct packed {
    logic                  rep_a;
    logic [ZeroCntW-1:0]   zeros;
    logic                  byte_en;
    logic [ByteW-1:0]      data;
    logic                  rep_b;
    logic [NumW-1:0]       num;
    logic [LengthBits-1:0] len_a;
    logic [LengthBits-1:0] len_b;
  } cmd_t;

  logic [1:0]            zero_run_q, zero_run_d;
  logic                  inside_q, inside_d;
  logic [LengthBits-1:0] count_q, count_d;
  logic [NumW-1:0]       ctr_q, ctr_d;

  logic                  accept;
  logic                  is_zero, is_start;
  logic [1:0]            z1;
  logic                  in1;
  logic [LengthBits-1:0] base;
  logic [NumW-1:0]       ctr1;
  logic [ZeroCntW-1:0]   pz, nz;
  logic                  byte_en, rep_a, rep_b;
  logic [LengthBits:0]   sum;
  logic [LengthBits-1:0] count1;
  cmd_t                  cmd;

  assign ready_o  = ~full_i;
  assign accept   = valid_i & ~full_i;
  assign is_zero  = (data_byte_i == '0);
  assign is_start = (data_byte_i == StartByte) && (zero_run_q >= StartMinZeros);

  always_comb begin
    z1      = zero_run_q;
    in1     = inside_q;
    base    = count_q;
    ctr1    = ctr_q;
    pz      = '0;
    byte_en = 1'b0;
    rep_a   = 1'b0;
    priority if (is_zero) begin
      // A fourth zero pushes the oldest held zero out as payload.
      if (zero_run_q < MaxHeldZeros) begin
        z1 = zero_run_q + 2'd1;
      end else begin
        pz = ZeroCntW'(1);
      end
    end else if (is_start) begin
      rep_a = inside_q;
      ctr1  = ctr_q + NumW'(1);
      in1   = 1'b1;
      base  = '0;
      z1    = '0;
    end else begin
      pz      = ZeroCntW'(zero_run_q);
      byte_en = inside_q;
      z1      = '0;
    end
    // At the end of the stream the held zeros go out as payload.
    if (end_of_stream_i) begin
      pz = pz + ZeroCntW'(z1);
    end
    nz     = in1 ? pz : '0;
    rep_b  = end_of_stream_i & in1;
    sum    = {1'b0, base} + (LengthBits + 1)'(nz) + (LengthBits + 1)'(byte_en);
    count1 = sum[LengthBits] ? {LengthBits{1'b1}} : sum[LengthBits-1:0];
  end

  always_comb begin
    cmd.rep_a   = rep_a;
    cmd.zeros   = nz;
    cmd.byte_en = byte_en;
    cmd.data    = data_byte_i;
    cmd.rep_b   = rep_b;
    cmd.num     = ctr1;
    cmd.len_a   = count_q;
    cmd.len_b   = count1;
  end

  assign cmd_o  = cmd;
  assign push_o = accept & (rep_a | rep_b | byte_en | (nz != '0));

  always_comb begin
    zero_run_d = zero_run_q;
    inside_d   = inside_q;
    count_d    = count_q;
    ctr_d      = ctr_q;
    if (accept) begin
      zero_run_d = end_of_stream_i ? 2'd0 : z1;
      inside_d   = end_of_stream_i ? 1'b0 : in1;
      count_d    = end_of_stream_i ? '0 : count1;
      ctr_d      = ctr1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
      inside_q   <= 1'b0;
      count_q    <= '0;
      ctr_q      <= '0;
    end else begin
      zero_run_q <= zero_run_d;
      inside_q   <= inside_d;
      count_q    <= count_d;
      ctr_q      <= ctr_d;
    end
  end

endmodule

/* hw/rtl/ncs_queue.sv */
// Small command queue that lets the front and back end stall independently.
module ncs_queue
  import ncs_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CntW'(QueueDepth));
  assign avail_o = (fill_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & avail_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/ncs_back.sv */
// Back end: expands each queued command into result items, one per cycle while the output is not stalled.
module ncs_back
  import ncs_pkg::*;
#(
  parameter int unsigned LengthBits = DefaultLengthBits,
  parameter int unsigned CmdW       = 3 + ZeroCntW + ByteW + NumW + 2 * LengthBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  logic [CmdW-1:0]      cmd_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 kind_o,
  output logic [ByteW-1:0]     payload_o,
  output logic [NumW-1:0]      nal_number_o,
  output logic [FieldLenW-1:0] nal_length_o,
  output logic                 last_o
);

  typedef struct packed {
    logic                  rep_a;
    logic [ZeroCntW-1:0]   zeros;
    logic                  byte_en;
    logic [ByteW-1:0]      data;
    logic                  rep_b;
    logic [NumW-1:0]       num;
    logic [LengthBits-1:0] len_a;
    logic [LengthBits-1:0] len_b;
  } cmd_t;

  localparam int unsigned WideW = (LengthBits > FieldLenW) ? LengthBits : FieldLenW;

  cmd_t                  cmd;
  logic                  done_a_q, done_a_d;
  logic [ZeroCntW-1:0]   zdone_q, zdone_d;
  logic                  done_b_q, done_b_d;
  logic                  valid_q, valid_d;
  kind_e                 kind_q, kind_d;
  logic [ByteW-1:0]      payload_q, payload_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [FieldLenW-1:0]  len_q, len_d;
  logic                  last_q, last_d;

  logic                  load;
  logic                  pend_a, pend_z, pend_b;
  logic                  is_last;
  logic [LengthBits-1:0] len_sel;
  logic [WideW-1:0]      len_wide;

  assign cmd    = cmd_t'(cmd_i);
  assign load   = avail_i & (~valid_q | ready_i);
  assign pend_a = cmd.rep_a & ~done_a_q;
  assign pend_z = (zdone_q < cmd.zeros);
  assign pend_b = cmd.byte_en & ~done_b_q;

  always_comb begin
    kind_d    = kind_q;
    payload_d = payload_q;
    num_d     = num_q;
    len_sel   = '0;
    len_d     = len_q;
    last_d    = last_q;
    is_last   = 1'b0;
    done_a_d  = done_a_q;
    zdone_d   = zdone_q;
    done_b_d  = done_b_q;
    // Results of one command go out as: report of the closed unit, released
    // zeros, the byte itself, and the report at the end of the stream.
    priority if (pend_a) begin
      kind_d    = KIND_REPORT;
      payload_d = '0;
      num_d     = cmd.num - NumW'(1);
      len_sel   = cmd.len_a;
      is_last   = (cmd.zeros == '0) & ~cmd.byte_en & ~cmd.rep_b;
      done_a_d  = 1'b1;
    end else if (pend_z) begin
      kind_d    = KIND_PAYLOAD;
      payload_d = '0;
      num_d     = cmd.num;
      is_last   = (zdone_q + ZeroCntW'(1) == cmd.zeros) & ~cmd.byte_en & ~cmd.rep_b;
      zdone_d   = zdone_q + ZeroCntW'(1);
    end else if (pend_b) begin
      kind_d    = KIND_PAYLOAD;
      payload_d = cmd.data;
      num_d     = cmd.num;
      is_last   = ~cmd.rep_b;
      done_b_d  = 1'b1;
    end else begin
      kind_d    = KIND_REPORT;
      payload_d = '0;
      num_d     = cmd.num;
      len_sel   = cmd.len_b;
      is_last   = 1'b1;
    end
    len_wide = WideW'(len_sel);
    len_d    = (len_wide > WideW'(FieldLenMax)) ? FieldLenMax : len_wide[FieldLenW-1:0];
    last_d   = is_last;
    if (is_last) begin
      done_a_d = 1'b0;
      zdone_d  = '0;
      done_b_d = 1'b0;
    end
  end

  assign pop_o = load & is_last;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      done_a_q <= 1'b0;
      zdone_q  <= '0;
      done_b_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        done_a_q <= done_a_d;
        zdone_q  <= zdone_d;
        done_b_q <= done_b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= kind_d;
      payload_q <= payload_d;
      num_q     <= num_d;
      len_q     <= len_d;
      last_q    <= last_d;
    end
  end

  assign valid_o      = valid_q;
  assign kind_o       = kind_q;
  assign payload_o    = payload_q;
  assign nal_number_o = num_q;
  assign nal_length_o = len_q;
  assign last_o       = last_q;

endmodule

/* hw/rtl/nal_start_code_splitter.sv */
// Top level of the H.264 Annex B NAL start code splitter.
//
//   Channel   Direction  tdata                                   tuser  tlast
//   s_axis    in         data_byte[7:0]                          -      end_of_stream
//   m_axis    out        payload, nal_number, nal_length [63:0]  kind   last
//
// The front end takes one byte per cycle whatever its value; it stalls only
// while the four-entry command queue is full. The back end sends one result
// item per cycle while m_axis_tready is high, up to five for a single byte.
// The command of an accepted byte passes through the queue and then the output
// register before its first result item appears.
// The output register holds its item while m_axis_tready is low; the reset
// empties the queue and the output register and clears all parser state.
module nal_start_code_splitter
  import ncs_pkg::*;
#(
  parameter int unsigned LengthBits = DefaultLengthBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // payload[7:0], nal_number[39:8], nal_length[63:40]
  output logic        m_axis_tuser,   // kind[0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CmdW = 3 + ZeroCntW + ByteW + NumW + 2 * LengthBits;

  logic                 push, full, pop, avail;
  logic [CmdW-1:0]      cmd_wr, cmd_rd;
  logic [ByteW-1:0]     payload;
  logic [NumW-1:0]      nal_number;
  logic [FieldLenW-1:0] nal_length;

  ncs_front #(
    .LengthBits(LengthBits),
    .CmdW      (CmdW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (s_axis_tdata),
    .end_of_stream_i(s_axis_tlast),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .push_o         (push),
    .cmd_o          (cmd_wr),
    .full_i         (full)
  );

  ncs_queue #(
    .Width(CmdW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_wr),
    .full_o (full),
    .pop_i  (pop),
    .avail_o(avail),
    .rdata_o(cmd_rd)
  );

  ncs_back #(
    .LengthBits(LengthBits),
    .CmdW      (CmdW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .cmd_i       (cmd_rd),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .payload_o   (payload),
    .nal_number_o(nal_number),
    .nal_length_o(nal_length),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {nal_length, nal_number, payload};

endmodule

/* tb/sv/nal_start_code_splitter_tb.sv */
// Self-checking testbench of the NAL start code splitter with a built-in predictor.
`timescale 1ns / 100ps

module nal_start_code_splitter_tb;
  import ncs_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned DirectedItems = 35;
  localparam int unsigned RandomItems   = 130;
  localparam logic [FieldLenW-1:0] CountLimit = {DefaultLengthBits{1'b1}};

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eos;
    logic             drain;  // hold this item back until every result is out
  } stream_byte_t;

  typedef struct packed {
    kind_e                kind;
    logic [ByteW-1:0]     payload;
    logic [NumW-1:0]      number;
    logic [FieldLenW-1:0] length;
    logic                 last;
  } nal_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  nal_start_code_splitter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  stream_byte_t pending_q[$];
  nal_result_t  expected_q[$];

  // Predictor state.
  logic [1:0]           held_zeros;
  logic                 unit_open;
  logic [FieldLenW-1:0] unit_bytes;
  logic [NumW-1:0]      unit_number;
  int                   item_results;

  int          mismatches;
  int          items_queued;
  int          items_accepted;
  int unsigned idle_cycles;
  logic        in_fire;
  int          send_gap;
  int          send_calm;
  int          stall_left;
  int          recv_calm;
  stream_byte_t cur_byte;
  nal_result_t  want;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("ERROR %s: got %0h, expected %0h", what, got, exp_val);
    mismatches++;
  endtask

  task automatic push_result(input kind_e kind, input logic [ByteW-1:0] pay,
                             input logic [FieldLenW-1:0] len);
    nal_result_t r;
    r.kind    = kind;
    r.payload = pay;
    r.number  = unit_number;
    r.length  = len;
    r.last    = 1'b0;
    expected_q.push_back(r);
    item_results++;
  endtask

  task automatic push_payload(input logic [ByteW-1:0] b);
    if (unit_open) begin
      if (unit_bytes != CountLimit) unit_bytes++;
      push_result(KIND_PAYLOAD, b, '0);
    end
  endtask

  task automatic predict_results(input logic [ByteW-1:0] b, input logic eos);
    nal_result_t tail;
    int k;
    item_results = 0;
    if (b == 8'h00) begin
      if (held_zeros < MaxHeldZeros) held_zeros++;
      else push_payload(8'h00);
    end else if (b == StartByte && held_zeros >= StartMinZeros) begin
      if (unit_open) push_result(KIND_REPORT, '0, unit_bytes);
      unit_number++;
      unit_open  = 1'b1;
      unit_bytes = '0;
      held_zeros = '0;
    end else begin
      for (k = 0; k < held_zeros; k++) push_payload(8'h00);
      held_zeros = '0;
      push_payload(b);
    end
    if (eos) begin
      for (k = 0; k < held_zeros; k++) push_payload(8'h00);
      if (unit_open) push_result(KIND_REPORT, '0, unit_bytes);
      held_zeros = '0;
      unit_open  = 1'b0;
      unit_bytes = '0;
    end
    if (item_results > 0) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Zeros and the start byte turn up far more often than in uniform data.
  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h00;
    if (r == 3) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_byte(input logic [7:0] data, input logic eos, input logic drain);
    stream_byte_t s;
    s.data  = data;
    s.eos   = eos;
    s.drain = drain;
    pending_q.push_back(s);
    items_queued++;
  endtask

  task automatic mark_eos();
    stream_byte_t s;
    s = pending_q.pop_back();
    s.eos = 1'b1;
    pending_q.push_back(s);
  endtask

  task automatic add_start_code(input int zeros, input logic drain);
    int k;
    for (k = 0; k < zeros; k++) add_byte(8'h00, 1'b0, drain && k == 0);
    add_byte(StartByte, 1'b0, 1'b0);
  endtask

  // Driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && expected_q.size() != 0)) begin
          cur_byte = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_byte.data;
          s_axis_tlast  <= cur_byte.eos;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = draw_gap();
            if ($urandom_range(0, 49) == 0) send_calm = 40;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 3) == 0) begin
          stall_left = draw_gap();
          if ($urandom_range(0, 49) == 0) recv_calm = 40;
        end
      end
    end
  end

  // Monitor, predictor call and watchdog.
  always @(posedge clk_i) begin
    in_fire = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (in_fire) begin
        predict_results(s_axis_tdata, s_axis_tlast);
        items_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, tdata[31:0]",
                          m_axis_tdata[31:0], '0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser != want.kind)
            report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
          if (m_axis_tdata[7:0] != want.payload)
            report_mismatch("payload", 32'(m_axis_tdata[7:0]), 32'(want.payload));
          if (m_axis_tdata[39:8] != want.number)
            report_mismatch("nal_number", m_axis_tdata[39:8], want.number);
          if (m_axis_tdata[63:40] != want.length)
            report_mismatch("nal_length", 32'(m_axis_tdata[63:40]), 32'(want.length));
          if (m_axis_tlast != want.last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      if (in_fire || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sel;
    int len;
    int k;
    logic drain;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    in_fire       = 1'b0;
    held_zeros    = '0;
    unit_open     = 1'b0;
    unit_bytes    = '0;
    unit_number   = '0;
    mismatches    = 0;
    items_queued  = 0;
    items_accepted = 0;
    idle_cycles   = 0;
    send_gap      = 0;
    send_calm     = 0;
    stall_left    = 0;
    recv_calm     = 0;

    // Bytes ahead of the first start code are dropped, a lone zero and one too.
    add_byte(8'h55, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_start_code(2, 1'b0);
    // Payload extremes; two held zeros are released ahead of an ordinary byte.
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h02, 1'b0, 1'b0);
    // Four-byte start code closes the first unit.
    add_start_code(3, 1'b1);
    // A fourth and fifth zero each push out the oldest held zero.
    for (k = 0; k < 5; k++) add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hAB, 1'b0, 1'b0);
    // Three held zeros and an end-of-stream byte give the most results.
    for (k = 0; k < 3; k++) add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    // A start code on the final byte reports the old unit and an empty new one.
    add_start_code(2, 1'b1);
    add_start_code(2, 1'b0);
    mark_eos();
    // End of stream with no unit open, and on a held zero.
    add_byte(8'h33, 1'b1, 1'b0);
    add_start_code(2, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);

    while (items_queued < DirectedItems + RandomItems) begin
      sel   = $urandom_range(0, 99);
      drain = ($urandom_range(0, 19) == 0);
      if (sel < 70) begin
        add_start_code($urandom_range(2, 3), drain);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        for (k = 0; k < len; k++) add_byte(body_byte(), 1'b0, 1'b0);
        if ($urandom_range(0, 4) == 0) mark_eos();
      end else if (sel < 85) begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) add_byte(8'($urandom_range(0, 255)), 1'b0, drain && k == 0);
        if ($urandom_range(0, 3) == 0) mark_eos();
      end else begin
        // Broken start codes: too few zeros before the one, or zeros then data.
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(0, 1);
          for (k = 0; k < len; k++) add_byte(8'h00, 1'b0, 1'b0);
          add_byte(8'h01, 1'b0, drain && len == 0);
        end else begin
          len = $urandom_range(4, 6);
          for (k = 0; k < len; k++) add_byte(8'h00, 1'b0, drain && k == 0);
          add_byte(8'($urandom_range(2, 255)), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) mark_eos();
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(negedge clk_i);
    while (items_accepted != items_queued || expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
